[design/prkm_pkg.sv]
`timescale 1ns / 1ps
package prkm_pkg;

  localparam int KEY_CHARS   = 16;
  localparam int MAX_KEYS    = 2;
  localparam int OFFSET_BITS = 32;

  localparam int CHAR_W     = 16;
  localparam int START_W    = 32;
  localparam int LEN_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int KEY_LEN_W  = 5;
  localparam int KEY_BITS   = 64;
  localparam int KEYS_W     = 2;
  localparam int MIN_LEN_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int FOLD_W     = 7;

  localparam logic [CHAR_W-1:0] PRINT_LO = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] PRINT_HI = CHAR_W'(126);
  localparam logic [7:0] UPPER_A   = 8'd65;
  localparam logic [7:0] UPPER_Z   = 8'd90;
  localparam logic [7:0] CASE_STEP = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_LOW   = CFG_IDX_W'(0),
    REG_FIRST_HIGH  = CFG_IDX_W'(1),
    REG_FIRST_LEN   = CFG_IDX_W'(2),
    REG_SECOND_LOW  = CFG_IDX_W'(3),
    REG_SECOND_HIGH = CFG_IDX_W'(4),
    REG_SECOND_LEN  = CFG_IDX_W'(5),
    REG_KEYS_IN_USE = CFG_IDX_W'(6),
    REG_MIN_RUN     = CFG_IDX_W'(7)
  } prkm_reg_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  first_low;
    logic [KEY_BITS-1:0]  first_high;
    logic [KEY_LEN_W-1:0] first_len;
    logic [KEY_BITS-1:0]  second_low;
    logic [KEY_BITS-1:0]  second_high;
    logic [KEY_LEN_W-1:0] second_len;
    logic [KEYS_W-1:0]    keys_in_use;
    logic [MIN_LEN_W-1:0] min_run_length;
  } prkm_cfg_t;

  // newest character at index 0
  typedef logic [KEY_CHARS-1:0][FOLD_W-1:0] prkm_window_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c + CASE_STEP;
    return r;
  endfunction

endpackage

[design/prkm_char_if.sv]
`timescale 1ns / 1ps
interface prkm_char_if;
  logic                          valid;
  logic                          ready;
  logic [prkm_pkg::CHAR_W-1:0]   char_value;
  logic                          region_last;
  logic                          new_scan;

  modport source (output valid, char_value, region_last, new_scan, input ready);
  modport sink (input valid, char_value, region_last, new_scan, output ready);
endinterface

[design/prkm_run_if.sv]
`timescale 1ns / 1ps
interface prkm_run_if;
  logic                          valid;
  logic                          ready;
  logic [prkm_pkg::START_W-1:0]  run_start;
  logic [prkm_pkg::LEN_W-1:0]    run_length;
  logic                          matched;
  logic                          key_index;
  logic [prkm_pkg::COUNT_W-1:0]  matched_count;

  modport source (output valid, run_start, run_length, matched, key_index, matched_count,
                  input ready);
  modport sink (input valid, run_start, run_length, matched, key_index, matched_count,
                output ready);
endinterface

[design/prkm_cfg_if.sv]
`timescale 1ns / 1ps
interface prkm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [prkm_pkg::CFG_IDX_W-1:0]   index;
  logic [prkm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/printable_run_keyword_matcher_core.sv]
`timescale 1ns / 1ps
// Printable-run keyword matcher: takes one character word per cycle unless the result output
// stalls (values 32 to 126 count as printable), tracks runs and their offsets in the region,
// and when a run ends at a non-printable character or at a region_last character, reports
// runs of at least min_run_length with a case-insensitive match against up to two keywords
// and a saturating matched-run count. A word is registered on input, processed once the
// result register is free or being read, and its result is registered; the limit is the
// combinational update of the run state and the 16-character window compare per keyword.
// Words that end no reportable run give no result.
module printable_run_keyword_matcher_core (
  input  logic       clk,
  input  logic       rst,
  prkm_char_if.sink  char_in,
  prkm_run_if.source run_out,
  prkm_cfg_if.sink   cfg
);

  localparam logic [prkm_pkg::LEN_W-1:0]   LEN_MAX   = '1;
  localparam logic [prkm_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [prkm_pkg::OFFSET_BITS-1:0] POS_MAX = '1;

  prkm_pkg::prkm_cfg_t regs;

  prkm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  logic                          s1_valid;
  logic [prkm_pkg::CHAR_W-1:0]   s1_char;
  logic                          s1_last;
  logic                          s1_new_scan;
  logic                          proc;

  assign proc          = s1_valid && (!run_out.valid || run_out.ready);
  assign char_in.ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_char     <= char_in.char_value;
      s1_last     <= char_in.region_last;
      s1_new_scan <= char_in.new_scan;
    end
  end

  // run state
  logic [prkm_pkg::OFFSET_BITS-1:0] position, position_next;
  logic [prkm_pkg::OFFSET_BITS-1:0] current_start, current_start_next;
  logic [prkm_pkg::LEN_W-1:0]       current_length, current_length_next;
  prkm_pkg::prkm_window_t           lower_window, lower_window_next;
  logic                             found_flag, found_flag_next;
  logic                             found_index, found_index_next;
  logic [prkm_pkg::COUNT_W-1:0]     match_total, match_total_next;

  logic                             printable;
  logic [prkm_pkg::FOLD_W-1:0]      fc;
  logic                             act1, act2;
  logic [prkm_pkg::LEN_W-1:0]       len_inc;
  logic [prkm_pkg::LEN_W-1:0]       run_len_now;
  logic                             hit0, hit1;
  logic                             end_run, emit;
  logic                             m0, m1, m;
  logic [prkm_pkg::MIN_LEN_W-1:0]   min_eff;
  logic                             found_mid, index_mid;

  assign printable = s1_char >= prkm_pkg::PRINT_LO && s1_char <= prkm_pkg::PRINT_HI;
  assign fc        = prkm_pkg::FOLD_W'(prkm_pkg::fold(s1_char[7:0]));
  assign act1      = regs.keys_in_use != '0;
  assign act2      = (prkm_pkg::MAX_KEYS >= 2) && (regs.keys_in_use >= prkm_pkg::KEYS_W'(2));
  assign len_inc   = (current_length == LEN_MAX) ? current_length : current_length + 1'b1;
  // run length including this word when it is printable
  assign run_len_now = printable ? len_inc : current_length;
  assign min_eff   = (regs.min_run_length == '0) ? prkm_pkg::MIN_LEN_W'(1)
                                                 : regs.min_run_length;

  always_comb begin
    for (int i = prkm_pkg::KEY_CHARS - 1; i > 0; i--) lower_window_next[i] = lower_window[i-1];
    lower_window_next[0] = fc;
    if (!printable) lower_window_next = lower_window;
  end

  prkm_key_match u_key0 (
    .key_low  (regs.first_low),
    .key_high (regs.first_high),
    .key_len  (regs.first_len),
    .window   (lower_window_next),
    .run_len  (len_inc),
    .hit      (hit0)
  );

  prkm_key_match u_key1 (
    .key_low  (regs.second_low),
    .key_high (regs.second_high),
    .key_len  (regs.second_len),
    .window   (lower_window_next),
    .run_len  (len_inc),
    .hit      (hit1)
  );

  always_comb begin
    current_start_next  = current_start;
    current_length_next = current_length;
    found_mid           = found_flag;
    index_mid           = found_index;
    match_total_next    = s1_new_scan ? '0 : match_total;

    if (printable) begin
      if (current_length == '0) current_start_next = position;
      current_length_next = len_inc;
      // first keyword overrides an earlier second-keyword find
      if (act1 && hit0) begin
        found_mid = 1'b1;
        index_mid = 1'b0;
      end else if (act2 && !found_flag && hit1) begin
        found_mid = 1'b1;
        index_mid = 1'b1;
      end
    end

    end_run = (!printable || s1_last) && (run_len_now != '0);
    emit    = end_run && (run_len_now >= prkm_pkg::LEN_W'(min_eff));
    m0 = act1 && (regs.first_len == '0 || (found_mid && !index_mid));
    m1 = act2 && (regs.second_len == '0 || (found_mid && index_mid));
    m  = m0 || m1;
    if (emit && m && match_total_next != COUNT_MAX) match_total_next = match_total_next + 1'b1;

    found_flag_next  = found_mid;
    found_index_next = index_mid;
    if (end_run) begin
      current_length_next = '0;
      found_flag_next     = 1'b0;
      found_index_next    = 1'b0;
    end

    if (s1_last) position_next = '0;
    else if (position != POS_MAX) position_next = position + 1'b1;
    else position_next = position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      current_start  <= '0;
      current_length <= '0;
      lower_window   <= '0;
      found_flag     <= 1'b0;
      found_index    <= 1'b0;
      match_total    <= '0;
    end else if (proc) begin
      position       <= position_next;
      current_start  <= current_start_next;
      current_length <= current_length_next;
      lower_window   <= lower_window_next;
      found_flag     <= found_flag_next;
      found_index    <= found_index_next;
      match_total    <= match_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_out.valid <= 1'b0;
    end else if (proc && emit) begin
      run_out.valid <= 1'b1;
    end else if (run_out.ready) begin
      run_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      run_out.run_start     <= prkm_pkg::START_W'(current_start_next);
      run_out.run_length    <= run_len_now;
      run_out.matched       <= m;
      run_out.key_index     <= !m0 && m1;
      run_out.matched_count <= match_total_next;
    end
  end

`ifndef SYNTH
  a_stall_keeps_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !proc |=> s1_valid)
    else $error("input word lost while stalled");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_out.valid |-> run_out.run_length != '0)
    else $error("empty run reported");
  a_count_on_match: assert property (@(posedge clk) disable iff (rst)
    run_out.valid && run_out.matched |-> run_out.matched_count != '0)
    else $error("matched run with zero count");
  a_index_needs_match: assert property (@(posedge clk) disable iff (rst)
    run_out.valid && run_out.key_index |-> run_out.matched)
    else $error("key index set without match");
`endif

endmodule

[design/prkm_cfg_regs.sv]
`timescale 1ns / 1ps
module prkm_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  prkm_cfg_if.sink            cfg,
  output prkm_pkg::prkm_cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_low      <= '0;
      regs.first_high     <= '0;
      regs.first_len      <= '0;
      regs.second_low     <= '0;
      regs.second_high    <= '0;
      regs.second_len     <= '0;
      regs.keys_in_use    <= prkm_pkg::KEYS_W'(1);
      regs.min_run_length <= prkm_pkg::MIN_LEN_W'(5);
    end else if (cfg.valid) begin
      case (prkm_pkg::prkm_reg_t'(cfg.index))
        prkm_pkg::REG_FIRST_LOW:   regs.first_low   <= cfg.data;
        prkm_pkg::REG_FIRST_HIGH:  regs.first_high  <= cfg.data;
        prkm_pkg::REG_FIRST_LEN:   regs.first_len   <= cfg.data[prkm_pkg::KEY_LEN_W-1:0];
        prkm_pkg::REG_SECOND_LOW:  regs.second_low  <= cfg.data;
        prkm_pkg::REG_SECOND_HIGH: regs.second_high <= cfg.data;
        prkm_pkg::REG_SECOND_LEN:  regs.second_len  <= cfg.data[prkm_pkg::KEY_LEN_W-1:0];
        prkm_pkg::REG_KEYS_IN_USE: regs.keys_in_use <= cfg.data[prkm_pkg::KEYS_W-1:0];
        prkm_pkg::REG_MIN_RUN:     regs.min_run_length <= cfg.data[prkm_pkg::MIN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/prkm_key_match.sv]
`timescale 1ns / 1ps
module prkm_key_match (
  input  logic [prkm_pkg::KEY_BITS-1:0]  key_low,
  input  logic [prkm_pkg::KEY_BITS-1:0]  key_high,
  input  logic [prkm_pkg::KEY_LEN_W-1:0] key_len,
  input  prkm_pkg::prkm_window_t         window,
  input  logic [prkm_pkg::LEN_W-1:0]     run_len,
  output logic                           hit
);

  logic [2*prkm_pkg::KEY_BITS-1:0] key_all;
  logic [prkm_pkg::KEY_CHARS:1]    len_eq;

  assign key_all = {key_high, key_low};

  // one comparator set per possible keyword length, then select by key_len
  always_comb begin
    logic eq;
    logic [7:0] kb;
    len_eq = '0;
    for (int l = 1; l <= prkm_pkg::KEY_CHARS; l++) begin
      eq = 1'b1;
      for (int j = 0; j < l; j++) begin
        kb = prkm_pkg::fold(key_all[8*j +: 8]);
        if (kb != {1'b0, window[l-1-j]}) eq = 1'b0;
      end
      len_eq[l] = eq && (key_len == prkm_pkg::KEY_LEN_W'(l));
    end
  end

  assign hit = (|len_eq) && (run_len >= prkm_pkg::LEN_W'(key_len));

endmodule
